// ===== rtl/mdss_pkg.sv =====
// Package for the multiplexed decimal seven-segment unit.
// Holds the sequencer state type, the control struct and the digit pattern decoder.
// No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package mdss_pkg;

   // Width of the binary value taken by a load.
   localparam int unsigned VALUE_W    = 16;
   // Decimal digits needed to hold any 16-bit value.
   localparam int unsigned BCD_DIGITS = 5;
   localparam int unsigned BCD_W      = 4 * BCD_DIGITS;
   // Width of the shift counter of the binary-to-decimal conversion.
   localparam int unsigned STEP_W     = 4;
   localparam int unsigned SEG_W      = 7;
   localparam int unsigned EN_W       = 4;

   // Request kinds carried in tuser.
   localparam logic REQ_LOAD = 1'b0;
   localparam logic REQ_SCAN = 1'b1;

   // Pattern for the digit 0, used for positions above the converted digits.
   localparam logic [SEG_W-1:0] SEG_ZERO = 7'h3F;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_CONVERT,
      ST_FINISH
   } state_type;

   // Control from the sequencer to the pattern store and drive.
   typedef struct packed {
      logic store_write;
      logic scan_tick;
   } ctrl_type;

   // Active-high segment pattern, bit 0 = a up to bit 6 = g.
   function automatic logic [SEG_W-1:0] seg_of(input logic [3:0] digit);
      logic [SEG_W-1:0] seg;
      case (digit)
         4'd0: seg = 7'h3F;
         4'd1: seg = 7'h06;
         4'd2: seg = 7'h5B;
         4'd3: seg = 7'h4F;
         4'd4: seg = 7'h66;
         4'd5: seg = 7'h6D;
         4'd6: seg = 7'h7D;
         4'd7: seg = 7'h07;
         4'd8: seg = 7'h7F;
         4'd9: seg = 7'h6F;
         default: seg = '0;
      endcase
      return seg;
   endfunction

endpackage

`default_nettype wire

// ===== rtl/mdss_dabble.sv =====
// Iterative binary-to-decimal converter: one add-3-and-shift step per cycle.
// Depends on mdss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdss_dabble (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            start,
   input  wire logic [mdss_pkg::VALUE_W-1:0]    value,
   output logic                                 done,
   output logic [mdss_pkg::BCD_W-1:0]           bcd
);

   logic [mdss_pkg::VALUE_W-1:0] bin_ff, bin_in;
   logic [mdss_pkg::BCD_W-1:0]   bcd_ff, bcd_in;
   logic [mdss_pkg::STEP_W-1:0]  step_ff, step_in;
   logic                         busy_ff, busy_in;
   logic                         done_ff, done_in;
   logic [mdss_pkg::BCD_W-1:0]   adjusted;

   // Each decimal digit of five or more gets three added before the shift.
   always_comb begin
      for (int i = 0; i < int'(mdss_pkg::BCD_DIGITS); i++) begin
         adjusted[4*i +: 4] = (bcd_ff[4*i +: 4] >= 4'd5) ?
                              bcd_ff[4*i +: 4] + 4'd3 : bcd_ff[4*i +: 4];
      end
   end

   always_comb begin
      bin_in  = bin_ff;
      bcd_in  = bcd_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         bin_in  = value;
         bcd_in  = '0;
         step_in = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         bcd_in  = {adjusted[mdss_pkg::BCD_W-2:0], bin_ff[mdss_pkg::VALUE_W-1]};
         bin_in  = {bin_ff[mdss_pkg::VALUE_W-2:0], 1'b0};
         step_in = step_ff + 1'b1;
         if (step_ff == '1) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
   end

   always_ff @(posedge clock) begin
      bin_ff <= bin_in;
      bcd_ff <= bcd_in;
   end

   assign done = done_ff;
   assign bcd  = bcd_ff;

endmodule

`default_nettype wire

// ===== rtl/mdss_scan.sv =====
// Pattern store, scan position and segment/enable drive registers.
// Depends on mdss_pkg.
`timescale 1ns / 1ps
`default_nettype none

module mdss_scan #(
   parameter int unsigned DIGITS = 4
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire mdss_pkg::ctrl_type            ctrl,
   input  wire logic [mdss_pkg::BCD_W-1:0]    bcd,
   output logic [mdss_pkg::SEG_W-1:0]         segment_drive,
   output logic [mdss_pkg::EN_W-1:0]          enable_drive
);

   localparam int unsigned POS_W = (DIGITS > 1) ? $clog2(DIGITS) : 1;

   logic [mdss_pkg::SEG_W-1:0] store_ff [DIGITS];
   logic [mdss_pkg::SEG_W-1:0] pattern_in [DIGITS];
   logic [POS_W-1:0]           pos_ff, pos_in;
   logic [mdss_pkg::SEG_W-1:0] seg_ff, seg_in;
   logic [mdss_pkg::EN_W-1:0]  en_ff, en_in;
   logic [mdss_pkg::EN_W-1:0]  en_onehot;

   // Positions beyond the converted digits are loaded with the pattern for 0.
   for (genvar g = 0; g < int'(DIGITS); g++) begin : g_pattern
      if (g < int'(mdss_pkg::BCD_DIGITS)) begin : g_conv
         assign pattern_in[g] = mdss_pkg::seg_of(bcd[4*g +: 4]);
      end else begin : g_zero
         assign pattern_in[g] = mdss_pkg::SEG_ZERO;
      end
   end

   // Digits at position four and up have no enable line and read as all off.
   always_comb begin
      for (int i = 0; i < int'(mdss_pkg::EN_W); i++) begin
         en_onehot[i] = (int'(pos_ff) == i);
      end
   end

   always_comb begin
      pos_in = pos_ff;
      seg_in = seg_ff;
      en_in  = en_ff;
      if (ctrl.scan_tick) begin
         seg_in = store_ff[pos_ff];
         en_in  = en_onehot;
         pos_in = (int'(pos_ff) == int'(DIGITS) - 1) ? '0 : pos_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
         seg_ff <= '0;
         en_ff  <= '0;
         for (int i = 0; i < int'(DIGITS); i++) begin
            store_ff[i] <= '0;
         end
      end else begin
         pos_ff <= pos_in;
         seg_ff <= seg_in;
         en_ff  <= en_in;
         if (ctrl.store_write) begin
            for (int i = 0; i < int'(DIGITS); i++) begin
               store_ff[i] <= pattern_in[i];
            end
         end
      end
   end

   assign segment_drive = seg_ff;
   assign enable_drive  = en_ff;

endmodule

`default_nettype wire

// ===== rtl/multiplexed_decimal_seven_segment_unit.sv =====
// Top level of the multiplexed decimal seven-segment unit: sequencer and result register.
// Depends on mdss_pkg, mdss_dabble and mdss_scan.
//
// Usage. Items arrive on the req_ stream. req_tuser selects the kind: a load
// carries a 16-bit unsigned number in req_tdata, a scan tick ignores req_tdata.
// Every item yields exactly one item on the rsp_ stream, holding the segment
// drive and the digit enable (one-hot or all off) as they stand after that item.
// A load converts the number to decimal with the add-3-and-shift unit, one
// binary bit per cycle, then writes the pattern store and fills the result
// register, which raises rsp_tvalid. Its result repeats the present drive
// unchanged. A scan tick drives the stored pattern of the current position,
// lights that digit and steps the position on; its result goes into the result
// register from the finish state. req_tready is high only while the sequencer
// is idle, and the sequencer returns to idle in the cycle that fills the result
// register, so a new item is taken only after the previous one has reached the
// result register.
// A finished result waits in the rsp_ register; the next item may already be
// accepted, and its result is held back until the receiver has taken the
// earlier one, so a stalled receiver loses nothing.
// Reset (synchronous, active high) blanks the pattern store, clears the drive
// and the scan position, and leaves the output stream empty.
`timescale 1ns / 1ps
`default_nettype none

module multiplexed_decimal_seven_segment_unit #(
   parameter int unsigned DIGITS = 4
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [15:0] req_tdata,   // [15:0] value
   input  wire logic        req_tuser,   // [0] req_type: 0 load, 1 scan tick
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic [15:0]      rsp_tdata    // [6:0] segments, [10:7] digit_enable, [15:11] zero
);

   mdss_pkg::state_type state_ff, state_in;
   mdss_pkg::ctrl_type  ctrl;

   logic                          accept;
   logic                          dabble_start;
   logic                          dabble_done;
   logic [mdss_pkg::BCD_W-1:0]    bcd;
   logic [mdss_pkg::SEG_W-1:0]    segment_drive;
   logic [mdss_pkg::EN_W-1:0]     enable_drive;
   logic                          rsp_load;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [15:0]                   rsp_data_ff, rsp_data_in;

   assign accept = req_tvalid && req_tready;

   // The converter does the decimal split for a load.
   mdss_dabble u_dabble (
      .clock (clock),
      .reset (reset),
      .start (dabble_start),
      .value (req_tdata),
      .done  (dabble_done),
      .bcd   (bcd)
   );

   // The pattern store and the multiplex drive.
   mdss_scan #(
      .DIGITS (DIGITS)
   ) u_scan (
      .clock         (clock),
      .reset         (reset),
      .ctrl          (ctrl),
      .bcd           (bcd),
      .segment_drive (segment_drive),
      .enable_drive  (enable_drive)
   );

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         mdss_pkg::ST_IDLE: begin
            if (accept) begin
               state_in = (req_tuser == mdss_pkg::REQ_LOAD) ?
                          mdss_pkg::ST_CONVERT : mdss_pkg::ST_FINISH;
            end
         end
         mdss_pkg::ST_CONVERT: begin
            if (dabble_done) begin
               state_in = mdss_pkg::ST_FINISH;
            end
         end
         mdss_pkg::ST_FINISH: begin
            if (!rsp_valid_ff || rsp_tready) begin
               state_in = mdss_pkg::ST_IDLE;
            end
         end
         default: state_in = mdss_pkg::ST_IDLE;
      endcase
   end

   // Sequencer outputs.
   always_comb begin
      req_tready       = 1'b0;
      dabble_start     = 1'b0;
      ctrl.store_write = 1'b0;
      ctrl.scan_tick   = 1'b0;
      rsp_load         = 1'b0;
      case (state_ff)
         mdss_pkg::ST_IDLE: begin
            req_tready     = 1'b1;
            dabble_start   = req_tvalid && (req_tuser == mdss_pkg::REQ_LOAD);
            ctrl.scan_tick = req_tvalid && (req_tuser == mdss_pkg::REQ_SCAN);
         end
         mdss_pkg::ST_CONVERT: begin
            ctrl.store_write = dabble_done;
         end
         mdss_pkg::ST_FINISH: begin
            rsp_load = !rsp_valid_ff || rsp_tready;
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   // Result register: filled from the drive once the previous result has gone.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'b0, enable_drive, segment_drive};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mdss_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule

`default_nettype wire

// ===== rtl/mdss_checker.sv =====
// Port-level checker for the multiplexed decimal seven-segment unit, with its bind.
// Depends on multiplexed_decimal_seven_segment_unit.
`timescale 1ns / 1ps
`default_nettype none

module mdss_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_tvalid,
   input wire logic        req_tready,
   input wire logic        rsp_tvalid,
   input wire logic        rsp_tready,
   input wire logic [15:0] rsp_tdata
);

   // A stalled result item holds its value.
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result item changed while stalled");

   // At most one digit is lit at a time.
   a_enable_onehot: assert property (@(posedge clock)
      $onehot0(rsp_tdata[10:7]) || !rsp_tvalid)
      else $error("more than one digit enable set");

   // Reset leaves the result stream empty.
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result item present after reset");

   // One item at a time: the unit is busy in the cycle after taking an item.
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("second item taken while the first is still at work");

endmodule

bind multiplexed_decimal_seven_segment_unit mdss_checker u_mdss_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

`default_nettype wire
